@@ src/smx_pkg.sv @@
// shared parameters, types and instruction codes for the stack execute unit
package smx_pkg;

  localparam int unsigned StackDepthDef = 256;
  localparam int unsigned ValueWidthDef = 32;
  localparam int unsigned FuncW = 8;
  localparam int unsigned IoW = 32;
  localparam int unsigned DepthOutW = 9;

  // instruction character codes
  localparam logic [7:0] ChSpace = 8'h20;
  localparam logic [7:0] ChTab = 8'h09;
  localparam logic [7:0] ChEast = 8'h3e;
  localparam logic [7:0] ChWest = 8'h3c;
  localparam logic [7:0] ChStop = 8'h40;
  localparam logic [7:0] ChTramp = 8'h23;
  localparam logic [7:0] ChHif = 8'h5f;
  localparam logic [7:0] ChNot = 8'h21;
  localparam logic [7:0] ChAdd = 8'h2b;
  localparam logic [7:0] ChSub = 8'h2d;
  localparam logic [7:0] ChMul = 8'h2a;
  localparam logic [7:0] ChDiv = 8'h2f;
  localparam logic [7:0] ChRem = 8'h25;
  localparam logic [7:0] ChGt = 8'h60;
  localparam logic [7:0] ChPop = 8'h24;
  localparam logic [7:0] ChDup = 8'h3a;
  localparam logic [7:0] ChSwap = 8'h5c;
  localparam logic [7:0] ChInNum = 8'h26;
  localparam logic [7:0] ChInChr = 8'h7e;
  localparam logic [7:0] ChOutNum = 8'h2e;
  localparam logic [7:0] ChOutChr = 8'h2c;
  localparam logic [7:0] ChZero = 8'h30;
  localparam logic [7:0] ChNine = 8'h39;

  localparam logic [1:0] DirKeep = 2'd0;
  localparam logic [1:0] DirEast = 2'd1;
  localparam logic [1:0] DirWest = 2'd2;

  typedef enum logic [3:0] {
    ST_IDLE, ST_RD1, ST_RD2, ST_WAIT1, ST_WAIT2, ST_MUL, ST_DIV, ST_WB1, ST_WB2, ST_OUT
  } smx_state_t;

  typedef struct packed {
    logic start;
    logic want_rem;
  } smx_div_req_t;

endpackage

@@ src/smx_ram.sv @@
// generic single-port write, single-port read ram with registered read
module smx_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

@@ src/smx_div.sv @@
// iterative truncating signed divider, one quotient bit per cycle
module smx_div import smx_pkg::*; #(
  parameter int unsigned Vw = ValueWidthDef
) (
  input  logic          clk,
  input  logic          rst_n,
  input  smx_div_req_t  req,
  input  logic [Vw-1:0] dividend,
  input  logic [Vw-1:0] divisor,
  output logic          done,
  output logic [Vw-1:0] result
);
  localparam int unsigned CntW = $clog2(Vw + 1);

  logic [Vw-1:0]   quo_r, quo_nxt;
  logic [Vw:0]     rem_r, rem_nxt;
  logic [Vw-1:0]   dvs_r, dvs_nxt;
  logic [CntW-1:0] cnt_r, cnt_nxt;
  logic            busy_r, busy_nxt;
  logic            neg_r, neg_nxt;
  logic            zero_r, zero_nxt;
  logic            rem_sel_r, rem_sel_nxt;
  logic            done_r, done_nxt;
  logic [Vw:0]     trial;
  logic [Vw-1:0]   mag_a, mag_b, raw;

  always_comb begin
    mag_a = divisor[Vw-1] ? (~divisor + 1'b1) : divisor;
    mag_b = dividend[Vw-1] ? (~dividend + 1'b1) : dividend;
    trial = {rem_r[Vw-1:0], quo_r[Vw-1]} - {1'b0, dvs_r};
    quo_nxt = quo_r; rem_nxt = rem_r; dvs_nxt = dvs_r; cnt_nxt = cnt_r;
    busy_nxt = busy_r; neg_nxt = neg_r; zero_nxt = zero_r;
    rem_sel_nxt = rem_sel_r; done_nxt = 1'b0;
    if (req.start) begin
      quo_nxt = mag_b; rem_nxt = '0; dvs_nxt = mag_a;
      cnt_nxt = CntW'(Vw); busy_nxt = 1'b1;
      zero_nxt = (divisor == '0); rem_sel_nxt = req.want_rem;
      neg_nxt = req.want_rem ? dividend[Vw-1] : (dividend[Vw-1] ^ divisor[Vw-1]);
    end else if (busy_r) begin
      if (!trial[Vw]) begin
        rem_nxt = trial;
        quo_nxt = {quo_r[Vw-2:0], 1'b1};
      end else begin
        rem_nxt = {rem_r[Vw-1:0], quo_r[Vw-1]};
        quo_nxt = {quo_r[Vw-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CntW'(1)) begin
        busy_nxt = 1'b0; done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0; done_r <= 1'b0; cnt_r <= '0;
    end else begin
      busy_r <= busy_nxt; done_r <= done_nxt; cnt_r <= cnt_nxt;
    end
    quo_r <= quo_nxt; rem_r <= rem_nxt; dvs_r <= dvs_nxt;
    neg_r <= neg_nxt; zero_r <= zero_nxt; rem_sel_r <= rem_sel_nxt;
  end

  assign raw = rem_sel_r ? rem_r[Vw-1:0] : quo_r;
  assign done = done_r;
  assign result = zero_r ? '0 : (neg_r ? (~raw + 1'b1) : raw);
endmodule

@@ src/stack_machine_execute_unit.sv @@
// top level: instruction decode and stack sequencer around the stack ram
// throughput: one instruction at a time; the next request is taken once the sequencer
//   is back in idle, and a waiting result only holds the capture of the next result
// reset: rst_n synchronous active low clears the depth count, sequencer and
//   result valid; stack ram contents are undefined until written
module stack_machine_execute_unit import smx_pkg::*; #(
  parameter int unsigned STACK_DEPTH = StackDepthDef,
  parameter int unsigned VALUE_WIDTH = ValueWidthDef
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [FuncW-1:0]     in_func,
  input  logic signed [IoW-1:0] in_in_value,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [1:0]           out_dir_change,
  output logic                 out_halt,
  output logic                 out_skip_next,
  output logic                 out_reflect,
  output logic                 out_out_valid,
  output logic                 out_out_is_number,
  output logic signed [IoW-1:0] out_out_value,
  output logic                 out_overflow,
  output logic [DepthOutW-1:0] out_depth_now
);
  localparam int unsigned Aw = $clog2(STACK_DEPTH);
  localparam int unsigned Cw = $clog2(STACK_DEPTH + 1);
  localparam int unsigned Vw = VALUE_WIDTH;

  smx_state_t state_r, state_nxt;
  logic [Cw-1:0] cnt_r, cnt_nxt;
  logic [7:0]    func_r, func_nxt;
  logic [Vw-1:0] inval_r, inval_nxt;
  logic [Vw-1:0] a_r, a_nxt, b_r, b_nxt;
  logic [Vw-1:0] mul_r, mul_nxt;
  logic          ovf_r, ovf_nxt;
  logic [Vw-1:0] x_r, x_nxt;

  // result register
  logic          ov_r, ov_nxt;
  logic [1:0]    rdir_r, rdir_nxt;
  logic          rhalt_r, rhalt_nxt, rskip_r, rskip_nxt, rrefl_r, rrefl_nxt;
  logic          rov_r, rov_nxt, rnum_r, rnum_nxt, rovf_r, rovf_nxt;
  logic [IoW-1:0] rval_r, rval_nxt;

  // ram
  logic          we;
  logic [Aw-1:0] waddr, raddr;
  logic [Vw-1:0] wdata, rdata;

  smx_div_req_t  dreq;
  logic          ddone;
  logic [Vw-1:0] dres;

  smx_ram #(.Width(Vw), .Depth(STACK_DEPTH)) u_ram (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
  );

  smx_div #(.Vw(Vw)) u_div (
    .clk(clk), .rst_n(rst_n), .req(dreq), .dividend(b_r), .divisor(a_r),
    .done(ddone), .result(dres)
  );

  logic is_digit, two_pop, one_pop, is_gt;
  logic [Vw-1:0] alu;

  always_comb begin
    is_digit = (func_r >= ChZero) && (func_r <= ChNine);
    two_pop = (func_r == ChAdd) || (func_r == ChSub) || (func_r == ChMul) ||
              (func_r == ChDiv) || (func_r == ChRem) || (func_r == ChGt) ||
              (func_r == ChSwap);
    one_pop = (func_r == ChHif) || (func_r == ChNot) || (func_r == ChPop) ||
              (func_r == ChDup) || (func_r == ChOutNum) || (func_r == ChOutChr);
    is_gt = $signed(b_r) > $signed(a_r);
    unique case (func_r)
      ChAdd:   alu = b_r + a_r;
      ChSub:   alu = b_r - a_r;
      ChMul:   alu = mul_r;
      ChDiv, ChRem: alu = dres;
      ChGt:    alu = {{(Vw-1){1'b0}}, is_gt};
      default: alu = '0;
    endcase
  end

  always_comb begin
    state_nxt = state_r; cnt_nxt = cnt_r; func_nxt = func_r; inval_nxt = inval_r;
    a_nxt = a_r; b_nxt = b_r; mul_nxt = mul_r; ovf_nxt = ovf_r;
    x_nxt = x_r;
    ov_nxt = ov_r; rdir_nxt = rdir_r; rhalt_nxt = rhalt_r; rskip_nxt = rskip_r;
    rrefl_nxt = rrefl_r; rov_nxt = rov_r; rnum_nxt = rnum_r; rovf_nxt = rovf_r;
    rval_nxt = rval_r;
    we = 1'b0; waddr = cnt_r[Aw-1:0]; wdata = x_r;
    raddr = Aw'(cnt_r - 1'b1);
    dreq = '0;
    in_ready = 1'b0;

    if (ov_r && out_ready) begin
      ov_nxt = 1'b0;
    end

    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          func_nxt = in_func;
          inval_nxt = Vw'(in_in_value);
          a_nxt = '0; b_nxt = '0; ovf_nxt = 1'b0;
          state_nxt = ST_RD1;
        end
      end
      ST_RD1: begin
        // issue first pop read, decide path
        if (two_pop || one_pop) begin
          if (cnt_r != '0) begin
            cnt_nxt = cnt_r - 1'b1;
            state_nxt = ST_WAIT1;
          end else begin
            state_nxt = two_pop ? ST_RD2 : ST_WB1;
          end
        end else begin
          state_nxt = ST_WB1;
        end
      end
      ST_WAIT1: begin
        a_nxt = rdata;
        state_nxt = two_pop ? ST_RD2 : ST_WB1;
      end
      ST_RD2: begin
        if (cnt_r != '0) begin
          cnt_nxt = cnt_r - 1'b1;
          state_nxt = ST_WAIT2;
        end else begin
          state_nxt = ST_MUL;
        end
      end
      ST_WAIT2: begin
        b_nxt = rdata;
        state_nxt = ST_MUL;
      end
      ST_MUL: begin
        mul_nxt = b_r * a_r;
        if (func_r == ChDiv || func_r == ChRem) begin
          dreq.start = 1'b1;
          dreq.want_rem = (func_r == ChRem);
          state_nxt = ST_DIV;
        end else begin
          state_nxt = ST_WB1;
        end
      end
      ST_DIV: begin
        if (ddone) state_nxt = ST_WB1;
      end
      ST_WB1: begin
        // first push, value chosen by instruction
        priority if (is_digit) begin
          wdata = Vw'(func_r - ChZero);
        end else if (func_r == ChNot) begin
          wdata = {{(Vw-1){1'b0}}, (a_r == '0)};
        end else if (func_r == ChSwap) begin
          wdata = a_r;
        end else if (func_r == ChInNum || func_r == ChInChr) begin
          wdata = inval_r;
        end else if (func_r == ChDup) begin
          wdata = a_r;
        end else begin
          wdata = alu;
        end
        x_nxt = (func_r == ChSwap) ? b_r : a_r;
        if (is_digit || func_r == ChNot || func_r == ChInNum || func_r == ChInChr ||
            func_r == ChDup || (two_pop && func_r != ChSwap) || func_r == ChSwap) begin
          if (cnt_r >= Cw'(STACK_DEPTH)) begin
            ovf_nxt = 1'b1;
          end else begin
            we = 1'b1;
            cnt_nxt = cnt_r + 1'b1;
          end
        end
        state_nxt = (func_r == ChDup || func_r == ChSwap) ? ST_WB2 : ST_OUT;
      end
      ST_WB2: begin
        wdata = x_r;
        if (cnt_r >= Cw'(STACK_DEPTH)) begin
          ovf_nxt = 1'b1;
        end else begin
          we = 1'b1;
          cnt_nxt = cnt_r + 1'b1;
        end
        state_nxt = ST_OUT;
      end
      ST_OUT: begin
        if (!ov_r || out_ready) begin
          ov_nxt = 1'b1;
          rdir_nxt = (func_r == ChEast) ? DirEast :
                     (func_r == ChWest) ? DirWest :
                     (func_r == ChHif) ? ((a_r == '0) ? DirEast : DirWest) : DirKeep;
          rhalt_nxt = (func_r == ChStop);
          rskip_nxt = (func_r == ChTramp);
          rrefl_nxt = !(is_digit || two_pop || one_pop || func_r == ChEast ||
                        func_r == ChWest || func_r == ChStop || func_r == ChTramp ||
                        func_r == ChSpace || func_r == ChTab || func_r == ChInNum ||
                        func_r == ChInChr);
          rov_nxt = (func_r == ChOutNum) || (func_r == ChOutChr);
          rnum_nxt = (func_r == ChOutNum);
          rval_nxt = rov_nxt ? IoW'($signed(a_r)) : '0;
          rovf_nxt = ovf_r;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE; cnt_r <= '0; ov_r <= 1'b0;
    end else begin
      state_r <= state_nxt; cnt_r <= cnt_nxt; ov_r <= ov_nxt;
    end
    func_r <= func_nxt; inval_r <= inval_nxt; a_r <= a_nxt; b_r <= b_nxt;
    mul_r <= mul_nxt; ovf_r <= ovf_nxt; x_r <= x_nxt;
    rdir_r <= rdir_nxt; rhalt_r <= rhalt_nxt; rskip_r <= rskip_nxt;
    rrefl_r <= rrefl_nxt; rov_r <= rov_nxt; rnum_r <= rnum_nxt;
    rovf_r <= rovf_nxt; rval_r <= rval_nxt;
  end

  // depth reported at result capture
  logic [DepthOutW-1:0] depth_r;
  always_ff @(posedge clk) begin
    if (state_r == ST_OUT && (!ov_r || out_ready)) begin
      depth_r <= DepthOutW'(cnt_r);
    end
  end

  assign out_valid = ov_r;
  assign out_dir_change = rdir_r;
  assign out_halt = rhalt_r;
  assign out_skip_next = rskip_r;
  assign out_reflect = rrefl_r;
  assign out_out_valid = rov_r;
  assign out_out_is_number = rnum_r;
  assign out_out_value = rval_r;
  assign out_overflow = rovf_r;
  assign out_depth_now = depth_r;
endmodule

@@ src/smx_checker.sv @@
// port-level checker for the stack execute unit, bound to the top level
module smx_checker import smx_pkg::*; (
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic [1:0] out_dir_change,
  input logic out_halt,
  input logic out_skip_next,
  input logic out_reflect,
  input logic out_out_valid,
  input logic out_out_is_number
);
  // one result per request: no new request taken in the cycle after one
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("request taken back to back");

  a_dir_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_dir_change != 2'd3))
    else $error("bad direction code");

  a_num_flag: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_out_is_number) |-> out_out_valid)
    else $error("number flag without output value");

  a_flags_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $onehot0({out_halt, out_skip_next, out_reflect, out_out_valid}))
    else $error("exclusive flags together");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> out_valid)
    else $error("result dropped");
endmodule

bind stack_machine_execute_unit smx_checker u_smx_checker (
  .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
  .out_valid(out_valid), .out_ready(out_ready), .out_dir_change(out_dir_change),
  .out_halt(out_halt), .out_skip_next(out_skip_next), .out_reflect(out_reflect),
  .out_out_valid(out_out_valid), .out_out_is_number(out_out_is_number)
);

@@ test/tb.sv @@
// testbench for the stack execute unit: random and directed instruction streams
module tb;
  import smx_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int Depth = 256;

  // one request to the unit
  typedef struct {
    logic [7:0] func;
    logic [31:0] val;
  } instr_t;

  // one predicted result
  typedef struct {
    logic [1:0] dir;
    logic halt;
    logic skip;
    logic refl;
    logic ovalid;
    logic onum;
    logic [31:0] oval;
    logic ovf;
    logic [8:0] depth;
  } outcome_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [7:0] in_func = '0;
  logic signed [31:0] in_in_value = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [1:0] out_dir_change;
  logic out_halt, out_skip_next, out_reflect, out_out_valid, out_out_is_number;
  logic signed [31:0] out_out_value;
  logic out_overflow;
  logic [8:0] out_depth_now;

  instr_t pending_q[$];
  outcome_t expected_q[$];
  int errors = 0;
  bit stim_done = 0;

  // predictor copy of the stack
  logic [31:0] stk[Depth];
  int unsigned sp = 0;
  logic ovf_seen;

  stack_machine_execute_unit dut (.*);

  always #5 clk = ~clk;

  function automatic logic [31:0] stk_pop();
    if (sp == 0) return '0;
    sp--;
    return stk[sp];
  endfunction

  function automatic void stk_push(logic [31:0] v);
    if (sp >= Depth) begin
      ovf_seen = 1'b1;
      return;
    end
    stk[sp] = v;
    sp++;
  endfunction

  // truncating signed divide/remainder, zero divisor gives 0
  function automatic logic [31:0] trunc_div(logic [31:0] b, logic [31:0] a, bit rem);
    logic [31:0] ua, ub, r;
    if (a == 0) return '0;
    ua = a[31] ? -a : a;
    ub = b[31] ? -b : b;
    r = rem ? ub % ua : ub / ua;
    if (rem ? b[31] : (b[31] ^ a[31])) r = -r;
    return r;
  endfunction

  // execute one instruction on the predictor stack
  function automatic outcome_t execute_instr(instr_t it);
    outcome_t o;
    logic [31:0] a, b, x;
    o = '{default: '0};
    ovf_seen = 1'b0;
    if (it.func >= ChZero && it.func <= ChNine) stk_push(32'(it.func - ChZero));
    else begin
      case (it.func)
        ChSpace, ChTab: ;
        ChEast: o.dir = DirEast;
        ChWest: o.dir = DirWest;
        ChStop: o.halt = 1'b1;
        ChTramp: o.skip = 1'b1;
        ChHif: o.dir = (stk_pop() == 0) ? DirEast : DirWest;
        ChNot: stk_push((stk_pop() == 0) ? 32'd1 : 32'd0);
        ChAdd, ChSub, ChMul, ChDiv, ChRem, ChGt: begin
          a = stk_pop();
          b = stk_pop();
          case (it.func)
            ChAdd: x = b + a;
            ChSub: x = b - a;
            ChMul: x = b * a;
            ChDiv: x = trunc_div(b, a, 0);
            ChRem: x = trunc_div(b, a, 1);
            default: x = ($signed(b) > $signed(a)) ? 32'd1 : 32'd0;
          endcase
          stk_push(x);
        end
        ChPop: void'(stk_pop());
        ChDup: begin
          x = stk_pop();
          stk_push(x);
          stk_push(x);
        end
        ChSwap: begin
          a = stk_pop();
          b = stk_pop();
          stk_push(a);
          stk_push(b);
        end
        ChInNum, ChInChr: stk_push(it.val);
        ChOutNum, ChOutChr: begin
          o.ovalid = 1'b1;
          o.onum = (it.func == ChOutNum);
          o.oval = stk_pop();
        end
        default: o.refl = 1'b1;
      endcase
    end
    o.ovf = ovf_seen;
    o.depth = 9'(sp);
    return o;
  endfunction

  // idle length: mostly none or short, occasionally long
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $time);
    errors++;
  endtask

  // driver: holds the request until accepted, then waits a random gap
  int drv_gap = 0;
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) begin
        expected_q.push_back(execute_instr('{in_func, in_in_value}));
        drv_gap = gap_len();
      end
      if (!in_valid || in_ready) begin
        if (drv_gap == 0 && pending_q.size() > 0) begin
          instr_t it;
          it = pending_q.pop_front();
          in_func <= it.func;
          in_in_value <= it.val;
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
          if (drv_gap > 0) drv_gap--;
        end
      end
    end
  end

  // monitor: random back-pressure, compares each result with the oldest prediction
  int mon_gap = 0;
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (expected_q.size() == 0) begin
          report_mismatch("unexpected result", '0, '0);
        end else begin
          outcome_t e;
          e = expected_q.pop_front();
          if (out_dir_change !== e.dir) report_mismatch("dir_change", out_dir_change, e.dir);
          if (out_halt !== e.halt) report_mismatch("halt", out_halt, e.halt);
          if (out_skip_next !== e.skip) report_mismatch("skip_next", out_skip_next, e.skip);
          if (out_reflect !== e.refl) report_mismatch("reflect", out_reflect, e.refl);
          if (out_out_valid !== e.ovalid) report_mismatch("out_valid", out_out_valid, e.ovalid);
          if (out_out_is_number !== e.onum)
            report_mismatch("out_is_number", out_out_is_number, e.onum);
          if (out_out_value !== e.oval) report_mismatch("out_value", out_out_value, e.oval);
          if (out_overflow !== e.ovf) report_mismatch("overflow", out_overflow, e.ovf);
          if (out_depth_now !== e.depth) report_mismatch("depth_now", out_depth_now, e.depth);
        end
        mon_gap = gap_len();
      end
      if (mon_gap > 0) begin
        out_ready <= 1'b0;
        mon_gap--;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // instruction table for random picks
  logic [7:0] ops[] = '{ChSpace, ChTab, ChEast, ChWest, ChStop, ChTramp, ChHif, ChNot,
    ChAdd, ChSub, ChMul, ChDiv, ChRem, ChGt, ChPop, ChDup, ChSwap, ChInNum, ChInChr,
    ChOutNum, ChOutChr};

  function automatic logic [31:0] rand_val();
    case ($urandom_range(0, 5))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'hffff_ffff;
      3: return 32'($urandom_range(0, 9));
      default: return $urandom();
    endcase
  endfunction

  task automatic add_req(logic [7:0] f, logic [31:0] v);
    pending_q.push_back('{f, v});
  endtask

  initial begin
    int n;
    logic [7:0] f;
    // directed: empty-stack pops, most instructions, field extremes
    add_req(ChAdd, '0);          // empty stack pop gives 0
    add_req(ChOutNum, '0);
    add_req(ChHif, '0);
    add_req(ChInNum, 32'h8000_0000);
    add_req(ChInChr, 32'hffff_ffff);
    add_req(ChDiv, '0);          // most negative divided by -1
    add_req(ChInNum, 32'h8000_0000);
    add_req(ChInNum, 32'hffff_ffff);
    add_req(ChRem, '0);
    add_req(ChInNum, 32'h7fff_ffff);
    add_req(ChZero, '0);
    add_req(ChDiv, '0);          // divide by zero
    add_req(ChNine, '0);
    add_req(ChZero, '0);
    add_req(ChRem, '0);
    add_req(ChDup, '0);
    add_req(ChSwap, '0);
    add_req(ChGt, '0);
    add_req(ChNot, '0);
    add_req(ChOutChr, '0);
    add_req(8'hff, 32'hffff_ffff); // unknown: reflect
    add_req(8'h3f, '0);
    add_req(ChStop, '0);
    add_req(ChTramp, '0);
    add_req(ChEast, '0);
    // fill the stack past full, then dup on a full stack, then drain
    for (int i = 0; i < Depth + 3; i++) add_req(ChInNum, rand_val());
    add_req(ChDup, '0);
    add_req(ChSwap, '0);
    for (int i = 0; i < Depth + 2; i++) add_req(($urandom_range(0, 1) != 0) ? ChPop : ChOutNum, '0);
    // random: mostly known instructions, some raw bytes
    n = 0;
    while (n < 600) begin
      case ($urandom_range(0, 9))
        0, 1: f = ChZero + 8'($urandom_range(0, 9));
        2: f = 8'($urandom());
        default: f = ops[$urandom_range(0, ops.size() - 1)];
      endcase
      add_req(f, rand_val());
      n++;
    end
    stim_done = 1;
  end

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    wait (stim_done && pending_q.size() == 0 && !in_valid);
    wait (expected_q.size() == 0);
    repeat (60) @(posedge clk);
    if (errors == 0 && expected_q.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  initial begin
    #10ms;
    $display("FAILURE");
    $finish;
  end
endmodule
